FILE: sv/monthly_temperature_statistics_top_macros.svh
// ----------------------------------------------------------------------------
// monthly temperature statistics assertion macros
// shared property forms for the checks at the end of the top level
// ----------------------------------------------------------------------------
`ifndef MONTHLY_TEMPERATURE_STATISTICS_TOP_MACROS_SVH
`define MONTHLY_TEMPERATURE_STATISTICS_TOP_MACROS_SVH

// same-cycle implication
`define MTS_ASSERT_IMP(label, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("mts same-cycle check failed");

// next-cycle implication
`define MTS_ASSERT_NXT(label, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("mts next-cycle check failed");

`endif

FILE: sv/mts_pkg.sv
// ----------------------------------------------------------------------------
// mts_pkg
// types and constants shared by the monthly temperature statistics block
// ----------------------------------------------------------------------------
`default_nettype none

package mts_pkg;

    localparam int NUM_BINS  = 13;
    localparam int BIN_IDX_W = 4;
    localparam int ACT_W     = 2;
    localparam int MONTH_W   = 4;
    localparam int TEMP_W    = 8;
    localparam int CNT_W     = 21;
    localparam int SUM_W     = 28;
    localparam int LIMIT_W   = 25;

    localparam logic [LIMIT_W-1:0] MAX_SAMPLES = 25'd1048576;

    localparam logic [ACT_W-1:0] ACT_ADD   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_QUERY = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

    localparam logic [MONTH_W-1:0] MONTH_FIRST = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_LAST  = 4'd12;
    localparam logic [MONTH_W-1:0] YEAR_BIN    = 4'd0;

    localparam logic signed [TEMP_W-1:0] TEMP_HI = 8'sd99;
    localparam logic signed [TEMP_W-1:0] TEMP_LO = -8'sd99;

    typedef struct packed {
        logic [ACT_W-1:0]          action;
        logic [MONTH_W-1:0]        month;
        logic signed [TEMP_W-1:0]  temperature;
    } req_word_t;

    typedef struct packed {
        logic                      accepted;
        logic                      has_data;
        logic [CNT_W-1:0]          sample_count;
        logic signed [SUM_W-1:0]   sample_sum;
        logic signed [TEMP_W-1:0]  min_temp;
        logic signed [TEMP_W-1:0]  max_temp;
    } rsp_word_t;

    typedef struct packed {
        logic load;
        logic exec;
    } mts_cmd_t;

endpackage

`default_nettype wire

FILE: sv/mts_ctrl.sv
// ----------------------------------------------------------------------------
// mts_ctrl
// controller: takes a request word, runs it through the datapath once the
// response register is free, and tracks response valid
// ----------------------------------------------------------------------------
`default_nettype none

module mts_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output mts_pkg::mts_cmd_t  cmd
);
    import mts_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg;
    logic state_next;
    logic rsp_valid_reg;
    logic rsp_valid_next;
    logic slot_free;

    always_comb
    begin
        slot_free      = !rsp_valid_reg || !rsp_stall;
        cmd.load       = (state_reg == ST_IDLE) && req_valid;
        cmd.exec       = (state_reg == ST_EXEC) && slot_free;
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.load)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (cmd.exec)
                begin
                    state_next     = ST_IDLE;
                    rsp_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;

endmodule

`default_nettype wire

FILE: sv/mts_datapath.sv
// ----------------------------------------------------------------------------
// mts_datapath
// request register, the thirteen statistics bins and the response register
// ----------------------------------------------------------------------------
`default_nettype none

module mts_datapath (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire mts_pkg::mts_cmd_t cmd,
    input  wire mts_pkg::req_word_t req,
    output mts_pkg::rsp_word_t     rsp
);
    import mts_pkg::*;

    req_word_t                 item_reg;
    rsp_word_t                 rsp_reg;
    rsp_word_t                 rsp_next;

    logic [CNT_W-1:0]          cnt_reg  [NUM_BINS];
    logic [CNT_W-1:0]          cnt_next [NUM_BINS];
    logic signed [SUM_W-1:0]   sum_reg  [NUM_BINS];
    logic signed [SUM_W-1:0]   sum_next [NUM_BINS];
    logic signed [TEMP_W-1:0]  min_reg  [NUM_BINS];
    logic signed [TEMP_W-1:0]  min_next [NUM_BINS];
    logic signed [TEMP_W-1:0]  max_reg  [NUM_BINS];
    logic signed [TEMP_W-1:0]  max_next [NUM_BINS];

    logic signed [TEMP_W-1:0]  temp;
    logic signed [SUM_W-1:0]   temp_ext;
    logic                      is_add;
    logic                      is_query;
    logic                      is_clear;
    logic                      month_ok;
    logic                      temp_ok;
    logic                      room;
    logic                      add_ok;
    logic                      query_ok;
    logic [BIN_IDX_W-1:0]      rd_idx;

    always_comb
    begin
        temp     = item_reg.temperature;
        temp_ext = {{(SUM_W-TEMP_W){temp[TEMP_W-1]}}, temp};
        is_add   = (item_reg.action == ACT_ADD);
        is_query = (item_reg.action == ACT_QUERY);
        is_clear = (item_reg.action == ACT_CLEAR);
        month_ok = (item_reg.month >= MONTH_FIRST) && (item_reg.month <= MONTH_LAST);
        temp_ok  = (temp >= TEMP_LO) && (temp <= TEMP_HI);
        room     = ({{(LIMIT_W-CNT_W){1'b0}}, cnt_reg[0]} < MAX_SAMPLES);
        add_ok   = is_add && month_ok && temp_ok && room;
        query_ok = is_query && (item_reg.month <= MONTH_LAST);
        rd_idx   = query_ok ? item_reg.month : YEAR_BIN;

        rsp_next          = '0;
        rsp_next.accepted = add_ok || query_ok || is_clear;
        if (query_ok)
        begin
            rsp_next.has_data     = (cnt_reg[rd_idx] != '0);
            rsp_next.sample_count = cnt_reg[rd_idx];
            rsp_next.sample_sum   = sum_reg[rd_idx];
            rsp_next.min_temp     = min_reg[rd_idx];
            rsp_next.max_temp     = max_reg[rd_idx];
        end
    end

    always_comb
    begin
        for (int b = 0; b < NUM_BINS; b++)
        begin
            cnt_next[b] = cnt_reg[b];
            sum_next[b] = sum_reg[b];
            min_next[b] = min_reg[b];
            max_next[b] = max_reg[b];
            if (cmd.exec && is_clear)
            begin
                cnt_next[b] = '0;
                sum_next[b] = '0;
                min_next[b] = TEMP_HI;
                max_next[b] = TEMP_LO;
            end
            else if (cmd.exec && add_ok
                     && (b == 0 || BIN_IDX_W'(b) == item_reg.month))
            begin
                cnt_next[b] = cnt_reg[b] + CNT_W'(1);
                sum_next[b] = sum_reg[b] + temp_ext;
                if (temp < min_reg[b])
                begin
                    min_next[b] = temp;
                end
                if (temp > max_reg[b])
                begin
                    max_next[b] = temp;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int b = 0; b < NUM_BINS; b++)
            begin
                cnt_reg[b] <= '0;
                sum_reg[b] <= '0;
                min_reg[b] <= TEMP_HI;
                max_reg[b] <= TEMP_LO;
            end
        end
        else
        begin
            for (int b = 0; b < NUM_BINS; b++)
            begin
                cnt_reg[b] <= cnt_next[b];
                sum_reg[b] <= sum_next[b];
                min_reg[b] <= min_next[b];
                max_reg[b] <= max_next[b];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= req;
        end
        if (cmd.exec)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp = rsp_reg;

endmodule

`default_nettype wire

FILE: sv/monthly_temperature_statistics_top.sv
// ----------------------------------------------------------------------------
// monthly_temperature_statistics_top
// Running count, sum, minimum and maximum over thirteen bins: bin 0 is the
// whole year, bins 1 to 12 the months. An add word updates the year bin and
// its month bin, a query word reads one bin, a clear word empties all bins.
// Every request word gives exactly one response word. A word is handled by
// first registering the request, then, once the response register is free,
// updating the bins and loading the response register. No new request is
// taken until that update is done, but the next request is taken while a
// response still waits.
// ----------------------------------------------------------------------------
`default_nettype none

`include "monthly_temperature_statistics_top_macros.svh"

module monthly_temperature_statistics_top (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_stall,
    input  wire mts_pkg::req_word_t req,
    output logic                    rsp_valid,
    input  wire logic               rsp_stall,
    output mts_pkg::rsp_word_t      rsp
);
    import mts_pkg::*;

    mts_cmd_t cmd;

    mts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd)
    );

    mts_datapath u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .req   (req),
        .rsp   (rsp)
    );

    `MTS_ASSERT_IMP(a_cmd_exclusive, cmd.load, !cmd.exec)
    `MTS_ASSERT_NXT(a_load_then_busy, cmd.load, req_stall)
    `MTS_ASSERT_NXT(a_exec_then_rsp, cmd.exec, rsp_valid && !req_stall)

endmodule

`default_nettype wire

FILE: verif/mts_stats_checker.sv
// ----------------------------------------------------------------------------
// mts_stats_checker
// Watches both channels of the monthly temperature statistics block, keeps
// its own copy of the thirteen bins, works out the response word for every
// request word taken and compares each response word field by field with the
// oldest one still pending.
// ----------------------------------------------------------------------------
`default_nettype none

module mts_stats_checker (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    input  wire logic               req_stall,
    input  wire mts_pkg::req_word_t req,
    input  wire logic               rsp_valid,
    input  wire logic               rsp_stall,
    input  wire mts_pkg::rsp_word_t rsp,
    output int                      mismatches,
    output int                      words_due
);

    timeunit 1ns;
    timeprecision 1ps;

    import mts_pkg::*;

    logic [CNT_W-1:0]         cnt_mirror  [NUM_BINS];
    logic signed [SUM_W-1:0]  sum_mirror  [NUM_BINS];
    logic signed [TEMP_W-1:0] low_mirror  [NUM_BINS];
    logic signed [TEMP_W-1:0] high_mirror [NUM_BINS];

    rsp_word_t replies_due [$];
    rsp_word_t oldest;
    int        mismatch_total = 0;
    int        due_now = 0;

    assign mismatches = mismatch_total;
    assign words_due  = due_now;

    function automatic void empty_bins();
        for (int b = 0; b < NUM_BINS; b++)
        begin
            cnt_mirror[b]  = '0;
            sum_mirror[b]  = '0;
            low_mirror[b]  = TEMP_HI;
            high_mirror[b] = TEMP_LO;
        end
    endfunction

    function automatic rsp_word_t apply_word(input req_word_t w);
        rsp_word_t                r;
        logic signed [TEMP_W-1:0] t;
        int                       b;
        r = '0;
        t = w.temperature;
        case (w.action)
            ACT_ADD:
            begin
                if (w.month >= MONTH_FIRST && w.month <= MONTH_LAST
                    && t >= TEMP_LO && t <= TEMP_HI
                    && cnt_mirror[YEAR_BIN] < MAX_SAMPLES)
                begin
                    for (int k = 0; k < 2; k++)
                    begin
                        b = (k == 0) ? int'(YEAR_BIN) : int'(w.month);
                        cnt_mirror[b] = cnt_mirror[b] + CNT_W'(1);
                        sum_mirror[b] = sum_mirror[b] + SUM_W'(t);
                        if (t < low_mirror[b])
                            low_mirror[b] = t;
                        if (t > high_mirror[b])
                            high_mirror[b] = t;
                    end
                    r.accepted = 1'b1;
                end
            end
            ACT_QUERY:
            begin
                if (w.month < NUM_BINS)
                begin
                    b              = int'(w.month);
                    r.accepted     = 1'b1;
                    r.has_data     = (cnt_mirror[b] != '0);
                    r.sample_count = cnt_mirror[b];
                    r.sample_sum   = sum_mirror[b];
                    r.min_temp     = low_mirror[b];
                    r.max_temp     = high_mirror[b];
                end
            end
            ACT_CLEAR:
            begin
                empty_bins();
                r.accepted = 1'b1;
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    task automatic compare_field(input string name, input logic signed [31:0] want,
                                 input logic signed [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            mismatch_total++;
        end
    endtask

    initial
        empty_bins();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            empty_bins();
            replies_due.delete();
            due_now <= 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (replies_due.size() == 0)
                begin
                    $display("%0t: word expected none actual %p", $time, rsp);
                    mismatch_total++;
                end
                else
                begin
                    oldest = replies_due.pop_front();
                    compare_field("accepted", 32'(oldest.accepted), 32'(rsp.accepted));
                    compare_field("has_data", 32'(oldest.has_data), 32'(rsp.has_data));
                    compare_field("sample_count", 32'(oldest.sample_count),
                                  32'(rsp.sample_count));
                    compare_field("sample_sum", 32'(oldest.sample_sum),
                                  32'(rsp.sample_sum));
                    compare_field("min_temp", 32'(oldest.min_temp), 32'(rsp.min_temp));
                    compare_field("max_temp", 32'(oldest.max_temp), 32'(rsp.max_temp));
                end
            end
            if (req_valid && !req_stall)
                replies_due.push_back(apply_word(req));
            due_now <= replies_due.size();
        end
    end

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives add, query and clear words into the monthly temperature statistics
// block: a short directed pass over range edges and rejected words, a long
// random mix of mostly valid words with some malformed ones, and a closing
// directed pass around a clear. Sender bursts and receiver stalls vary over
// the run; the checker beside the block predicts and compares every word.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import mts_pkg::*;

    localparam logic [ACT_W-1:0]   ACT_UNUSED  = 2'd3;
    localparam logic [MONTH_W-1:0] MONTH_MAX   = 4'd15;
    localparam int                 RANDOM_WORDS = 1630;
    localparam int                 CYCLE_LIMIT  = 6000000;
    localparam int                 REQ_W        = $bits(req_word_t);

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_stall;
    req_word_t req = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    rsp_word_t rsp;

    int        mismatches;
    int        words_due;
    int        cycle_count = 0;
    int        stall_mode = 0;
    int        stall_left = 0;
    req_word_t plan [$];

    monthly_temperature_statistics_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    mts_stats_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp        (rsp),
        .mismatches (mismatches),
        .words_due  (words_due)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // receiver stall pattern, switching between modes
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(8, 160);
        end
        else
            stall_left <= stall_left - 1;
        case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= ($urandom_range(0, 9) < 6);
            default: rsp_stall <= ((cycle_count % 5) >= 3);
        endcase
    end

    function automatic void plan_word(input logic [ACT_W-1:0] action, input int month,
                                      input int temp);
        req_word_t w;
        w.action      = action;
        w.month       = MONTH_W'(month);
        w.temperature = TEMP_W'(temp);
        plan.push_back(w);
    endfunction

    function automatic req_word_t random_word();
        req_word_t w;
        int        sel;
        sel           = $urandom_range(0, 99);
        w.action      = ACT_ADD;
        w.month       = MONTH_W'($urandom_range(MONTH_FIRST, MONTH_LAST));
        w.temperature = TEMP_W'(int'($urandom_range(0, 198)) - 99);
        if (sel >= 55 && sel < 80)
        begin
            w.action = ACT_QUERY;
            w.month  = MONTH_W'($urandom_range(YEAR_BIN, MONTH_LAST));
        end
        else if (sel >= 80 && sel < 83)
        begin
            w.action      = ACT_CLEAR;
            w.month       = MONTH_W'($urandom_range(0, MONTH_MAX));
            w.temperature = TEMP_W'($urandom_range(0, 255));
        end
        else if (sel >= 83)
            case ($urandom_range(0, 4))
                0: w.month = ($urandom_range(0, 1) == 0) ? YEAR_BIN
                                : MONTH_W'($urandom_range(MONTH_LAST + 1, MONTH_MAX));
                1: w.temperature = TEMP_W'($urandom_range(0, 255));
                2:
                begin
                    w.action      = ACT_UNUSED;
                    w.month       = MONTH_W'($urandom_range(0, MONTH_MAX));
                    w.temperature = TEMP_W'($urandom_range(0, 255));
                end
                3:
                begin
                    w.action = ACT_QUERY;
                    w.month  = MONTH_W'($urandom_range(MONTH_LAST + 1, MONTH_MAX));
                end
                default: w = REQ_W'($urandom);
            endcase
        return w;
    endfunction

    task automatic send_word(input req_word_t w);
        req       <= w;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    task automatic run_plan();
        int burst_left;
        int gap;
        burst_left = $urandom_range(1, 24);
        while (plan.size() > 0)
        begin
            send_word(plan.pop_front());
            burst_left--;
            if (burst_left == 0)
            begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                if (gap > 0)
                begin
                    req_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                         : $urandom_range(1, 24);
            end
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty bins, range edges, rejected words
        plan_word(ACT_QUERY, YEAR_BIN, 0);
        plan_word(ACT_QUERY, MONTH_LAST, -1);
        plan_word(ACT_ADD, MONTH_FIRST, TEMP_HI);
        plan_word(ACT_ADD, MONTH_LAST, TEMP_LO);
        plan_word(ACT_ADD, YEAR_BIN, 5);
        plan_word(ACT_ADD, MONTH_LAST + 1, 5);
        plan_word(ACT_ADD, MONTH_MAX, 0);
        plan_word(ACT_ADD, 6, TEMP_HI + 1);
        plan_word(ACT_ADD, 6, TEMP_LO - 1);
        plan_word(ACT_ADD, 6, 127);
        plan_word(ACT_ADD, 6, -128);
        plan_word(ACT_ADD, 6, 0);
        plan_word(ACT_QUERY, YEAR_BIN, 0);
        plan_word(ACT_QUERY, MONTH_FIRST, 0);
        plan_word(ACT_QUERY, MONTH_LAST, 0);
        plan_word(ACT_QUERY, 6, 0);
        plan_word(ACT_QUERY, MONTH_LAST + 1, 0);
        plan_word(ACT_QUERY, MONTH_MAX, 127);
        plan_word(ACT_UNUSED, 5, 7);
        plan_word(ACT_UNUSED, MONTH_MAX, -1);
        plan_word(ACT_CLEAR, MONTH_MAX, -128);
        plan_word(ACT_QUERY, YEAR_BIN, 0);
        plan_word(ACT_QUERY, MONTH_FIRST, 0);
        run_plan();

        for (int i = 0; i < RANDOM_WORDS; i++)
            plan.push_back(random_word());
        run_plan();

        // closing words around a clear
        plan_word(ACT_ADD, 3, 0);
        plan_word(ACT_ADD, MONTH_LAST, TEMP_LO);
        plan_word(ACT_QUERY, YEAR_BIN, 0);
        plan_word(ACT_QUERY, MONTH_LAST, 0);
        plan_word(ACT_CLEAR, YEAR_BIN, 0);
        plan_word(ACT_ADD, 3, TEMP_LO);
        plan_word(ACT_QUERY, YEAR_BIN, 0);
        run_plan();
        req_valid <= 1'b0;

        @(posedge clk);
        while (words_due != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
